### rtl/esd_pkg.sv
// shared types, constants and helpers for the epoch seconds to date converter
package esd_pkg;

  // number of register stages between the input and the result
  localparam int NUM_STAGES = 7;

  // seconds split: days = (secs >> 7) / 675, 86400 = 128 * 675
  localparam logic [25:0] DAY_RECIP       = 26'd50903317;  // ceil(2^35 / 675)
  localparam int          DAY_SHIFT       = 35;
  localparam logic [31:0] SECS_PER_DAY    = 32'd86400;

  // day count split into years of 365 days
  localparam logic [16:0] YEAR_RECIP      = 17'd91930;     // ceil(2^25 / 365)
  localparam int          YEAR_SHIFT      = 25;
  localparam logic [15:0] DAYS_PER_YEAR   = 16'd365;
  localparam logic [11:0] BASE_YEAR       = 12'd1970;

  // time of day split
  localparam logic [17:0] HOUR_RECIP      = 18'd149131;    // ceil(2^29 / 3600)
  localparam int          HOUR_SHIFT      = 29;
  localparam logic [16:0] SECS_PER_HOUR   = 17'd3600;
  localparam logic [12:0] MIN_RECIP       = 13'd4370;      // ceil(2^18 / 60)
  localparam int          MIN_SHIFT       = 18;
  localparam logic [11:0] SECS_PER_MINUTE = 12'd60;

  // year offset of 2100, the only century year in range that is not a leap year
  localparam logic [7:0]  OFS_2100        = 8'd130;
  localparam logic [7:0]  OFS_2101        = 8'd131;
  localparam logic [3:0]  MONTH_FEB       = 4'd1;
  localparam logic [3:0]  LAST_MONTH      = 4'd11;

  // first day of each month in a common year, counted from 0
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } esd_ctl_t;

  // leap days in the years from 1970 up to but not including 1970 + ofs
  function automatic logic [5:0] leaps_before(input logic [7:0] ofs);
    logic [8:0] cnt;
    cnt = (9'(ofs) + 9'd1) >> 2;
    if (ofs >= OFS_2101) begin
      cnt = cnt - 9'd1;
    end
    return cnt[5:0];
  endfunction

  // gregorian leap year test for year 1970 + ofs
  function automatic logic is_leap_ofs(input logic [7:0] ofs);
    return (ofs[1:0] == 2'd2) && (ofs != OFS_2100);
  endfunction

endpackage

### rtl/esd_pipe_ctrl.sv
// valid bits and per-stage load enables of the conversion pipeline
module esd_pipe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output esd_pkg::esd_ctl_t ctl
);
  import esd_pkg::*;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES:0]   rdy;

  // a stage can load when it is empty or its item moves on
  always_comb begin
    rdy[NUM_STAGES] = out_ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  // valid bits follow the data
  always_comb begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (rdy[i]) begin
        vld_nxt[i] = (i == 0) ? in_valid : vld_r[(i == 0) ? 0 : i - 1];
      end else begin
        vld_nxt[i] = vld_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.load  = rdy[NUM_STAGES-1:0];
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NUM_STAGES-1];
endmodule

### rtl/esd_day_split.sv
// stages 0-1: seconds split into whole days and seconds of the day
module esd_day_split (
  input  logic              clk,
  input  esd_pkg::esd_ctl_t ctl,
  input  logic [31:0]       epoch_seconds,
  output logic [15:0]       days,
  output logic [16:0]       tod
);
  import esd_pkg::*;

  logic [50:0] day_prod;
  logic [31:0] secs_r;
  logic [15:0] dq_r;
  logic [31:0] day_secs;
  logic [31:0] tod_full;
  logic [15:0] days_r;
  logic [16:0] tod_r;

  // days = (secs / 128) / 675 by reciprocal multiply
  assign day_prod = 51'(epoch_seconds[31:7]) * 51'(DAY_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      secs_r <= epoch_seconds;
      dq_r   <= day_prod[DAY_SHIFT +: 16];
    end
  end

  // seconds left in the day
  assign day_secs = 32'(dq_r) * SECS_PER_DAY;
  assign tod_full = secs_r - day_secs;

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      days_r <= dq_r;
      tod_r  <= tod_full[16:0];
    end
  end

  assign days = days_r;
  assign tod  = tod_r;
endmodule

### rtl/esd_date_calc.sv
// stages 2-6: day count to year, month and day of month
module esd_date_calc (
  input  logic              clk,
  input  esd_pkg::esd_ctl_t ctl,
  input  logic [15:0]       days,
  output logic [11:0]       year,
  output logic [3:0]        month,
  output logic [4:0]        day_of_month
);
  import esd_pkg::*;

  logic [32:0] year_prod;
  logic [15:0] days2_r;
  logic [7:0]  yq2_r;
  logic [15:0] year_days;
  logic [15:0] doy_full;
  logic [7:0]  ofs3_r;
  logic [8:0]  doy3_r;
  logic [5:0]  leaps_cur;
  logic [5:0]  leaps_prev;
  logic [7:0]  ofs4_nxt;
  logic [9:0]  doy4_nxt;
  logic [7:0]  ofs4_r;
  logic [8:0]  doy4_r;
  logic        leap5;
  logic [3:0]  month5_nxt;
  logic [8:0]  start5_nxt;
  logic [11:0] year5_r;
  logic [3:0]  month5_r;
  logic [8:0]  doy5_r;
  logic [8:0]  start5_r;
  logic [8:0]  dom_full;
  logic [11:0] year6_r;
  logic [3:0]  month6_r;
  logic [4:0]  dom6_r;

  // year estimate = days / 365
  assign year_prod = 33'(days) * 33'(YEAR_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      days2_r <= days;
      yq2_r   <= year_prod[YEAR_SHIFT +: 8];
    end
  end

  // day within the estimated year, before leap days
  assign year_days = 16'(yq2_r) * DAYS_PER_YEAR;
  assign doy_full  = days2_r - year_days;

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      ofs3_r <= yq2_r;
      doy3_r <= doy_full[8:0];
    end
  end

  // remove leap days; step back one year when they do not fit
  always_comb begin
    leaps_cur  = leaps_before(ofs3_r);
    leaps_prev = leaps_before(ofs3_r - 8'd1);
    if (doy3_r < 9'(leaps_cur)) begin
      ofs4_nxt = ofs3_r - 8'd1;
      doy4_nxt = 10'(doy3_r) + 10'(DAYS_PER_YEAR) - 10'(leaps_prev);
    end else begin
      ofs4_nxt = ofs3_r;
      doy4_nxt = 10'(doy3_r) - 10'(leaps_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      ofs4_r <= ofs4_nxt;
      doy4_r <= doy4_nxt[8:0];
    end
  end

  // month search: count month starts already passed
  always_comb begin
    leap5      = is_leap_ofs(ofs4_r);
    month5_nxt = '0;
    for (int m = 1; m <= 11; m++) begin
      if (doy4_r >= MONTH_START[m] + ((leap5 && m > 1) ? 9'd1 : 9'd0)) begin
        month5_nxt = 4'(m);
      end
    end
    start5_nxt = MONTH_START[month5_nxt] +
                 ((leap5 && month5_nxt > MONTH_FEB) ? 9'd1 : 9'd0);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      year5_r  <= 12'(ofs4_r) + BASE_YEAR;
      month5_r <= month5_nxt;
      doy5_r   <= doy4_r;
      start5_r <= start5_nxt;
    end
  end

  // day of month counted from 1
  assign dom_full = doy5_r - start5_r + 9'd1;

  always_ff @(posedge clk) begin
    if (ctl.load[6]) begin
      year6_r  <= year5_r;
      month6_r <= month5_r;
      dom6_r   <= dom_full[4:0];
    end
  end

  assign year         = year6_r;
  assign month        = month6_r;
  assign day_of_month = dom6_r;
endmodule

### rtl/esd_time_calc.sv
// stages 2-6: seconds of the day to hour, minute and second
module esd_time_calc (
  input  logic              clk,
  input  esd_pkg::esd_ctl_t ctl,
  input  logic [16:0]       tod,
  output logic [4:0]        hour,
  output logic [5:0]        minute,
  output logic [5:0]        second
);
  import esd_pkg::*;

  logic [34:0] hour_prod;
  logic [16:0] tod2_r;
  logic [4:0]  hour2_r;
  logic [16:0] hour_secs;
  logic [16:0] rem_full;
  logic [11:0] rem3_r;
  logic [4:0]  hour3_r;
  logic [24:0] min_prod;
  logic [11:0] rem4_r;
  logic [4:0]  hour4_r;
  logic [5:0]  min4_r;
  logic [11:0] min_secs;
  logic [11:0] sec_full;
  logic [4:0]  hour5_r;
  logic [5:0]  min5_r;
  logic [5:0]  sec5_r;
  logic [4:0]  hour6_r;
  logic [5:0]  min6_r;
  logic [5:0]  sec6_r;

  // hour = tod / 3600
  assign hour_prod = 35'(tod) * 35'(HOUR_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      tod2_r  <= tod;
      hour2_r <= hour_prod[HOUR_SHIFT +: 5];
    end
  end

  // seconds within the hour
  assign hour_secs = 17'(hour2_r) * SECS_PER_HOUR;
  assign rem_full  = tod2_r - hour_secs;

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      rem3_r  <= rem_full[11:0];
      hour3_r <= hour2_r;
    end
  end

  // minute = rem / 60
  assign min_prod = 25'(rem3_r) * 25'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      rem4_r  <= rem3_r;
      hour4_r <= hour3_r;
      min4_r  <= min_prod[MIN_SHIFT +: 6];
    end
  end

  // seconds within the minute
  assign min_secs = 12'(min4_r) * SECS_PER_MINUTE;
  assign sec_full = rem4_r - min_secs;

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      hour5_r <= hour4_r;
      min5_r  <= min4_r;
      sec5_r  <= sec_full[5:0];
    end
  end

  // align with the date path
  always_ff @(posedge clk) begin
    if (ctl.load[6]) begin
      hour6_r <= hour5_r;
      min6_r  <= min5_r;
      sec6_r  <= sec5_r;
    end
  end

  assign hour   = hour6_r;
  assign minute = min6_r;
  assign second = sec6_r;
endmodule

### rtl/epoch_seconds_to_calendar_date_unit.sv
// top level of the epoch seconds to calendar date and time converter
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into a Gregorian
// year, month (0 is January), day of month (from 1), hour, minute and second; 2100 is not a
// leap year. The block is a seven-stage pipeline built from constant reciprocal multiplies:
// it takes one item per cycle while in_ready is high, and each item moves through the stage
// registers in order and reaches the output from the last of them. A low out_ready holds the
// last stage and every full stage with no empty stage after it; items behind an empty stage
// keep moving, so in_ready only drops once all seven stages hold items.
module epoch_seconds_to_calendar_date_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second
);
  import esd_pkg::*;

  esd_ctl_t    ctl;
  logic [15:0] days;
  logic [16:0] tod;

  // handshake and stage enables
  esd_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  // seconds to days and seconds of the day
  esd_day_split u_day (
    .clk           (clk),
    .ctl           (ctl),
    .epoch_seconds (in_epoch_seconds),
    .days          (days),
    .tod           (tod)
  );

  // calendar date
  esd_date_calc u_date (
    .clk          (clk),
    .ctl          (ctl),
    .days         (days),
    .year         (out_year),
    .month        (out_month),
    .day_of_month (out_day_of_month)
  );

  // time of day
  esd_time_calc u_time (
    .clk    (clk),
    .ctl    (ctl),
    .tod    (tod),
    .hour   (out_hour),
    .minute (out_minute),
    .second (out_second)
  );
endmodule

### rtl/esd_checker.sv
// port-level checks of the converter and their binding to the top level
module esd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day_of_month,
  input logic [4:0]  out_hour,
  input logic [5:0]  out_minute,
  input logic [5:0]  out_second
);
  import esd_pkg::*;

  // a stalled result holds its date fields and its second
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_year) && $stable(out_month) &&
    $stable(out_day_of_month) && $stable(out_second))
    else $error("stalled item changed");

  // date fields stay within the calendar
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_year >= BASE_YEAR && out_year <= 12'd2106 &&
    out_month <= LAST_MONTH && out_day_of_month != 5'd0)
    else $error("date out of range");

  // february never runs past day 29, and only to 29 in leap years
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_month == MONTH_FEB |->
    out_day_of_month <= 5'd28 || (out_year[1:0] == 2'd0 && out_year != 12'd2100 &&
    out_day_of_month == 5'd29))
    else $error("bad february day");

  // time fields stay within the day
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hour <= 5'd23 && out_minute <= 6'd59 && out_second <= 6'd59)
    else $error("time of day out of range");
endmodule

bind epoch_seconds_to_calendar_date_unit esd_checker u_esd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_year         (out_year),
  .out_month        (out_month),
  .out_day_of_month (out_day_of_month),
  .out_hour         (out_hour),
  .out_minute       (out_minute),
  .out_second       (out_second)
);

### dv/testbench.sv
// self-checking testbench for the epoch seconds to calendar date converter
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // one converted date and time of day
  typedef struct {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } date_time_t;

  localparam int unsigned EPOCH_YEAR = 1970;
  localparam int unsigned ITEMS_PER_PHASE = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  epoch_seconds_to_calendar_date_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // gregorian rule: every fourth year, century years only every fourth century
  function automatic bit is_leap_year(input int unsigned y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 != 0) return 1'b1;
    return (y % 400) == 0;
  endfunction

  // leap days from 1970 up to but not including year y
  function automatic int unsigned leaps_since_1970(input int unsigned y);
    int unsigned p;
    if (y <= EPOCH_YEAR) return 0;
    p = y - 1;
    return (p / 4 - p / 100 + p / 400) - (1969 / 4 - 1969 / 100 + 1969 / 400);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
    int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    return lens[m] + ((leap && m == esd_pkg::MONTH_FEB) ? 1 : 0);
  endfunction

  // expected date and time for a timestamp
  function automatic date_time_t to_calendar(input logic [31:0] secs);
    date_time_t  r;
    int unsigned days, yr, doy, mon, tod;
    bit          leap;
    days = secs / 86400;
    yr   = days / 365 + EPOCH_YEAR;
    doy  = days % 365;
    // pull the year estimate down until the leftover days cover the leap days
    while (yr > EPOCH_YEAR && doy < leaps_since_1970(yr)) begin
      yr--;
      doy += 365;
    end
    doy  = doy - leaps_since_1970(yr);
    leap = is_leap_year(yr);
    mon  = 0;
    while (mon < esd_pkg::LAST_MONTH && doy >= days_in_month(mon, leap)) begin
      doy -= days_in_month(mon, leap);
      mon++;
    end
    tod = secs % 86400;
    r.year         = 12'(yr);
    r.month        = 4'(mon);
    r.day_of_month = 5'(doy + 1);
    r.hour         = 5'(tod / 3600);
    r.minute       = 6'((tod % 3600) / 60);
    r.second       = 6'(tod % 60);
    return r;
  endfunction

  // expected dates in item order, checked against the result stream
  class calendar_scoreboard;
    date_time_t  expected_dates[$];
    logic [31:0] expected_secs[$];
    int unsigned mismatch_count = 0;

    task report(input string what);
      $display("%0t: mismatch: %s", $realtime, what);
      mismatch_count++;
    endtask

    function void note_timestamp(input logic [31:0] secs);
      expected_dates.push_back(to_calendar(secs));
      expected_secs.push_back(secs);
    endfunction

    function int unsigned pending();
      return expected_dates.size();
    endfunction

    task check_date(input date_time_t got);
      date_time_t  exp;
      logic [31:0] secs;
      if (expected_dates.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      exp  = expected_dates.pop_front();
      secs = expected_secs.pop_front();
      if (got.year !== exp.year)
        report($sformatf("secs %0d year %0d, want %0d", secs, got.year, exp.year));
      if (got.month !== exp.month)
        report($sformatf("secs %0d month %0d, want %0d", secs, got.month, exp.month));
      if (got.day_of_month !== exp.day_of_month)
        report($sformatf("secs %0d day %0d, want %0d", secs, got.day_of_month,
                         exp.day_of_month));
      if (got.hour !== exp.hour)
        report($sformatf("secs %0d hour %0d, want %0d", secs, got.hour, exp.hour));
      if (got.minute !== exp.minute)
        report($sformatf("secs %0d minute %0d, want %0d", secs, got.minute, exp.minute));
      if (got.second !== exp.second)
        report($sformatf("secs %0d second %0d, want %0d", secs, got.second, exp.second));
    endtask
  endclass

  calendar_scoreboard dates_sb = new();

  // random timestamp: full range, month edges, or the top of the range
  function automatic logic [31:0] random_timestamp();
    int unsigned starts[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    int unsigned pick, y_off, mon, day;
    longint unsigned secs;
    pick = $urandom_range(9);
    if (pick < 4) return $urandom;
    if (pick == 9) return 32'hFFFF_FFFF - $urandom_range(5000000);
    y_off = $urandom_range(136);
    mon   = $urandom_range(11);
    day   = 365 * y_off + leaps_since_1970(EPOCH_YEAR + y_off) + starts[mon]
            + ((is_leap_year(EPOCH_YEAR + y_off) && mon > esd_pkg::MONTH_FEB) ? 1 : 0);
    case ($urandom_range(3))
      0: day = day;
      1: day = (day > 0) ? day - 1 : day;
      2: day = day + 1;
      default: day = day + $urandom_range(30);
    endcase
    case ($urandom_range(2))
      0: secs = longint'(day) * 86400;
      1: secs = longint'(day) * 86400 + 86399;
      default: secs = longint'(day) * 86400 + $urandom_range(86399);
    endcase
    if (secs > 64'hFFFF_FFFF) return 32'hFFFF_FFFF - $urandom_range(86399);
    return secs[31:0];
  endfunction

  // drive one item; called and returns at a falling edge
  task send_timestamp(input logic [31:0] secs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_epoch_seconds <= secs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    dates_sb.note_timestamp(secs);
    @(negedge clk);
  endtask

  // hold off new items until every result is back
  task drain_results();
    in_valid <= 1'b0;
    while (dates_sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    date_time_t got;
    if (rst_n && out_valid && out_ready) begin
      got.year         = out_year;
      got.month        = out_month;
      got.day_of_month = out_day_of_month;
      got.hour         = out_hour;
      got.minute       = out_minute;
      got.second       = out_second;
      dates_sb.check_date(got);
    end
  end

  // main sequence
  initial begin
    logic [31:0] edge_cases[$];
    int unsigned send_pcts[4] = '{0, 76, 0, 19};
    int unsigned recv_pcts[4] = '{0, 0, 76, 19};
    edge_cases = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd31535999,    // last second of 1970
      32'd31536000,    // first leap-free new year
      32'd68169600,    // 1972 leap day
      32'd68256000,    // first of march after a leap day
      32'd94694399,    // last second of a leap year
      32'd946684799,   // end of 1999
      32'd951782400,   // 2000 is a leap year
      32'd2147483647, 32'd2147483648,
      32'd4102444799,  // end of 2099
      32'd4107456000,  // 2100 february 28, not a leap year
      32'd4107542400,  // 2100 march 1
      32'd4294967294, 32'hFFFF_FFFF,
      32'hAAAA_AAAA, 32'h5555_5555
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed edges with no idling
    foreach (edge_cases[i]) send_timestamp(edge_cases[i]);
    drain_results();

    // random phases with no idling, sender gaps, receiver stalls, then both
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      repeat (ITEMS_PER_PHASE) send_timestamp(random_timestamp());
      drain_results();
    end

    repeat (esd_pkg::NUM_STAGES + 4) @(posedge clk);
    if (dates_sb.mismatch_count == 0 && dates_sb.pending() == 0) begin
      $display("PASS epoch_seconds_to_calendar_date_unit");
    end else begin
      $display("FAIL epoch_seconds_to_calendar_date_unit");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("FAIL epoch_seconds_to_calendar_date_unit");
    $finish;
  end

endmodule
